// ===== rtl/sdt_pkg.sv =====
// shared state codes for the squared distance transform unit
// no dependencies
package sdt_pkg;
	typedef logic [1:0] state_t;
	localparam state_t ST_LOAD  = 2'd0;
	localparam state_t ST_RUN   = 2'd1;
	localparam state_t ST_DRAIN = 2'd2;
	localparam state_t ST_OUT   = 2'd3;
endpackage

// ===== rtl/squared_distance_transform_1d_unit.sv =====
// top level of the 1d squared distance transform
// depends on sdt_pkg and sdt_sample_mem
//
// channel | beat fields                  | handshake
// input   | sample_value, sample_last    | in_valid, in_stall
// output  | distance_out, distance_last  | out_valid, out_stall
//
// samples load one per cycle into the sample store
// after the last sample, each position q scans all n stored samples through the
// single read port, then its result leaves as one output beat
// the input stalls from the last sample until the final result beat is taken
// reset clears control only; the store needs no clearing
// a stalled result holds in the output register
module squared_distance_transform_1d_unit #(
	parameter int LINE_LENGTH = 64,
	parameter int VALUE_WIDTH = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [VALUE_WIDTH-1:0] sample_value,
	input  logic                   sample_last,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [VALUE_WIDTH-1:0] distance_out,
	output logic                   distance_last
);
	localparam int IW = $clog2(LINE_LENGTH);
	localparam int CW = $clog2(LINE_LENGTH + 1);
	localparam int SW = VALUE_WIDTH + 2 * IW + 1;
	localparam logic [VALUE_WIDTH-1:0] INF = {VALUE_WIDTH{1'b1}};
	localparam logic [CW-1:0] LEN_C = CW'(LINE_LENGTH);

	sdt_pkg::state_t state_q;
	logic [CW-1:0] cnt_q;   // samples held
	logic [CW-1:0] n_q;     // line length being emitted
	logic [IW-1:0] q_q;     // output position
	logic [IW-1:0] v_q;     // read address being issued
	logic [VALUE_WIDTH-1:0] best_q;
	logic [VALUE_WIDTH-1:0] rd_data;
	logic          val_s1;
	logic          endf_s1;
	logic [IW-1:0] v_s1;

	logic in_acc;
	logic out_acc;
	assign in_stall = (state_q != sdt_pkg::ST_LOAD);
	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid && !out_stall;

	sdt_sample_mem #(.DEPTH(LINE_LENGTH), .WIDTH(VALUE_WIDTH)) u_mem (
		.clk     (clk),
		.wr_en   (in_acc),
		.wr_addr (cnt_q[IW-1:0]),
		.wr_data (sample_value),
		.rd_addr (v_q),
		.rd_data (rd_data)
	);

	// candidate f[v] + (q - v)^2, saturated, finite samples only
	logic [IW-1:0]            off;
	logic [2*IW-1:0]          off_sq;
	logic [SW-1:0]            sum;
	logic [VALUE_WIDTH-1:0]   cand;
	logic [VALUE_WIDTH-1:0]   best_nx;
	always_comb begin
		off    = (q_q >= v_s1) ? (q_q - v_s1) : (v_s1 - q_q);
		off_sq = {{IW{1'b0}}, off} * {{IW{1'b0}}, off};
		sum    = SW'(rd_data) + SW'(off_sq);
		if (rd_data == INF || sum >= SW'(INF)) begin
			cand = INF;
		end else begin
			cand = sum[VALUE_WIDTH-1:0];
		end
		best_nx = (val_s1 && cand < best_q) ? cand : best_q;
	end

	logic issue_last;
	assign issue_last = (CW'(v_q) == n_q - CW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= sdt_pkg::ST_LOAD;
			cnt_q     <= '0;
			n_q       <= '0;
			q_q       <= '0;
			v_q       <= '0;
			val_s1    <= 1'b0;
			endf_s1   <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			val_s1  <= 1'b0;
			endf_s1 <= 1'b0;
			case (state_q)
				sdt_pkg::ST_LOAD: begin
					if (in_acc) begin
						cnt_q <= cnt_q + CW'(1);
						if (sample_last || cnt_q == LEN_C - CW'(1)) begin
							n_q     <= cnt_q + CW'(1);
							q_q     <= '0;
							v_q     <= '0;
							state_q <= sdt_pkg::ST_RUN;
						end
					end
				end
				sdt_pkg::ST_RUN: begin
					// one read issued each cycle
					val_s1  <= 1'b1;
					endf_s1 <= issue_last;
					v_q     <= v_q + IW'(1);
					if (issue_last) begin
						state_q <= sdt_pkg::ST_DRAIN;
					end
				end
				sdt_pkg::ST_DRAIN: begin
					if (endf_s1) begin
						out_valid <= 1'b1;
						state_q   <= sdt_pkg::ST_OUT;
					end
				end
				sdt_pkg::ST_OUT: begin
					if (out_acc) begin
						out_valid <= 1'b0;
						v_q       <= '0;
						if (CW'(q_q) == n_q - CW'(1)) begin
							cnt_q   <= '0;
							state_q <= sdt_pkg::ST_LOAD;
						end else begin
							q_q     <= q_q + IW'(1);
							state_q <= sdt_pkg::ST_RUN;
						end
					end
				end
				default: begin
					state_q <= sdt_pkg::ST_LOAD;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		v_s1 <= v_q;
		if (state_q == sdt_pkg::ST_LOAD || out_acc) begin
			best_q <= INF;
		end else begin
			best_q <= best_nx;
		end
		if (state_q == sdt_pkg::ST_DRAIN && endf_s1) begin
			distance_out  <= best_nx;
			distance_last <= (CW'(q_q) == n_q - CW'(1));
		end
	end

	a_out_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid == (state_q == sdt_pkg::ST_OUT))
		else $error("result beat outside output state");
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != sdt_pkg::ST_LOAD) |-> (CW'(q_q) < n_q))
		else $error("output position beyond line");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= LEN_C)
		else $error("sample count beyond store");
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && distance_last) |=> (state_q == sdt_pkg::ST_LOAD && cnt_q == '0))
		else $error("line not closed after final beat");
endmodule

// ===== rtl/sdt_sample_mem.sv =====
// sample store: one write port, one registered read port
// no dependencies
module sdt_sample_mem #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 24
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule
